// ===== design/sais_pkg.sv =====
// ----------------------------------------------------------------------------
// sais_pkg
// Shared types and constants of the suffix array interval search core.
// ----------------------------------------------------------------------------
package sais_pkg;

  localparam int MAX_TEXT_DEF  = 4096;
  localparam int CHAR_BITS_DEF = 8;

  // Field widths fixed by the item format
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 13;
  localparam int POS_W   = 14;
  localparam int QCHAR_W = 8;
  localparam int ADDR_SPACE = 1 << IDX_W;

  localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

  // Opcodes
  localparam logic [1:0] OP_TEXT   = 2'd0;
  localparam logic [1:0] OP_SUFFIX = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ADDR,
    ST_SUF,
    ST_TXT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic take;       // an input item is accepted
    logic init;       // start the leftmost search over the interval
    logic sa_read;    // read suffix entry at the probe index
    logic tx_read;    // read text byte at suffix start plus match length
    logic step;       // halve the search range
    logic next_pass;  // save left edge, start the rightmost search
    logic commit;     // take the new interval
    logic halt;       // mark the query as stopped
    logic out_load;   // load the result register
  } sais_cmd_t;

  typedef struct packed {
    logic stopped;
    logic bad;
    logic l_lt_r;
    logic byte_eq;
    logic pass_right;
    logic out_busy;
  } sais_stat_t;

endpackage

// ===== design/sais_ram.sv =====
// ----------------------------------------------------------------------------
// sais_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sais_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sais_ctrl.sv =====
// ----------------------------------------------------------------------------
// sais_ctrl
// Sequencer of the search: issues probe reads and range updates for the
// leftmost and rightmost binary searches, then hands the result out.
// ----------------------------------------------------------------------------
module sais_ctrl import sais_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  input  sais_stat_t stat,
  output sais_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && opcode == OP_QUERY) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.stopped) begin
          state_next = ST_REPORT;
        end else if (stat.bad) begin
          cmd.halt   = 1'b1;
          state_next = ST_REPORT;
        end else begin
          cmd.init   = 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.sa_read = 1'b1;
        state_next  = ST_SUF;
      end
      ST_SUF: begin
        cmd.tx_read = 1'b1;
        state_next  = ST_TXT;
      end
      ST_TXT: begin
        if (stat.l_lt_r) begin
          cmd.step   = 1'b1;
          state_next = ST_ADDR;
        end else if (!stat.byte_eq) begin
          cmd.halt   = 1'b1;
          state_next = ST_REPORT;
        end else if (!stat.pass_right) begin
          cmd.next_pass = 1'b1;
          state_next    = ST_ADDR;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sais_dp.sv =====
// ----------------------------------------------------------------------------
// sais_dp
// Datapath: text and suffix stores, interval and search registers, probe
// compare and the result register.
// ----------------------------------------------------------------------------
module sais_dp import sais_pkg::*; #(
  parameter int MAX_TEXT  = MAX_TEXT_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic [1:0]         opcode,
  input  logic [IDX_W-1:0]   load_address,
  input  logic [IDX_W-1:0]   load_value,
  input  logic [QCHAR_W-1:0] query_char,
  input  logic               new_query,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [IDX_W-1:0]   lower_bound,
  output logic [IDX_W-1:0]   upper_bound,
  output logic [LEN_W-1:0]   match_length,
  output logic               extended,
  input  sais_cmd_t          cmd,
  output sais_stat_t         stat
);

  localparam int DEPTH = (MAX_TEXT < ADDR_SPACE) ? MAX_TEXT : ADDR_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  logic [LEN_W-1:0]     len;
  logic [IDX_W-1:0]     lo, hi, l, r, new_lo;
  logic [LEN_W-1:0]     count;
  logic                 stopped;
  logic                 pass_right;
  logic                 ext;
  logic [CHAR_BITS-1:0] c;
  logic                 pos_ok;

  logic [LEN_W-1:0]     len_m1;
  logic [LEN_W-1:0]     mid_sum;
  logic [IDX_W-1:0]     m;
  logic [IDX_W-1:0]     probe_idx;
  logic [IDX_W-1:0]     sa_rdata;
  logic [CHAR_BITS-1:0] tx_rdata;
  logic [CHAR_BITS-1:0] probe_byte;
  logic [POS_W-1:0]     pos;
  logic                 load_in_range;
  logic                 text_we, suffix_we;

  assign len_m1  = len - LEN_W'(1);
  assign mid_sum = {1'b0, l} + {1'b0, r} + LEN_W'(pass_right);
  assign m       = mid_sum[LEN_W-1:1];
  assign probe_idx = (l < r) ? m : l;

  assign pos = {2'b00, sa_rdata} + {1'b0, count};
  assign probe_byte = pos_ok ? tx_rdata : '0;

  assign load_in_range = {1'b0, load_address} < DEPTH_L;
  assign text_we   = cmd.take && opcode == OP_TEXT && load_in_range;
  assign suffix_we = cmd.take && opcode == OP_SUFFIX && load_in_range;

  sais_ram #(.WIDTH(CHAR_BITS), .DEPTH(DEPTH)) u_text (
    .clk   (clk),
    .we    (text_we),
    .waddr (load_address[AW-1:0]),
    .wdata (load_value[CHAR_BITS-1:0]),
    .re    (cmd.tx_read),
    .raddr (pos[AW-1:0]),
    .rdata (tx_rdata)
  );

  sais_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_suffix (
    .clk   (clk),
    .we    (suffix_we),
    .waddr (load_address[AW-1:0]),
    .wdata (load_value),
    .re    (cmd.sa_read),
    .raddr (probe_idx[AW-1:0]),
    .rdata (sa_rdata)
  );

  assign stat.stopped    = stopped;
  assign stat.bad        = ({1'b0, lo} >= len) || ({1'b0, hi} >= len) || (lo > hi);
  assign stat.l_lt_r     = l < r;
  assign stat.byte_eq    = probe_byte == c;
  assign stat.pass_right = pass_right;
  assign stat.out_busy   = out_valid && !out_ready;

  // Length register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_data == '0) begin
        len <= LEN_W'(1);
      end else if (cfg_data > DEPTH_L) begin
        len <= DEPTH_L;
      end else begin
        len <= cfg_data;
      end
    end
  end

  // Interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      lo      <= '0;
      hi      <= '0;
      count   <= '0;
      stopped <= 1'b0;
    end else if (cmd.take && opcode == OP_QUERY && new_query) begin
      lo      <= '0;
      hi      <= len_m1[IDX_W-1:0];
      count   <= '0;
      stopped <= 1'b0;
    end else if (cmd.commit) begin
      lo <= new_lo;
      hi <= l;
      if (count != COUNT_MAX) begin
        count <= count + LEN_W'(1);
      end
    end else if (cmd.halt) begin
      stopped <= 1'b1;
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (cmd.take && opcode == OP_QUERY) begin
      c   <= query_char[CHAR_BITS-1:0];
      ext <= 1'b0;
    end
    if (cmd.commit) begin
      ext <= 1'b1;
    end
    if (cmd.tx_read) begin
      pos_ok <= pos < {1'b0, len};
    end
    if (cmd.init) begin
      l          <= lo;
      r          <= hi;
      pass_right <= 1'b0;
    end else if (cmd.next_pass) begin
      new_lo     <= l;
      l          <= lo;
      r          <= hi;
      pass_right <= 1'b1;
    end else if (cmd.step) begin
      if (pass_right) begin
        if (probe_byte > c) begin
          r <= m - IDX_W'(1);
        end else begin
          l <= m;
        end
      end else begin
        if (probe_byte >= c) begin
          r <= m;
        end else begin
          l <= m + IDX_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lower_bound  <= lo;
      upper_bound  <= hi;
      match_length <= count;
      extended     <= ext;
    end
  end

endmodule

// ===== design/suffix_array_interval_search_core.sv =====
// ----------------------------------------------------------------------------
// suffix_array_interval_search_core
// Holds a text and its suffix array and narrows a suffix array interval by
// one query character per item, using a leftmost and a rightmost binary
// search on the byte at suffix start plus matched length.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_data           | in
//   in      | in_valid, in_ready, opcode, load_address,| in
//           | load_value, query_char, new_query        |
//   out     | out_valid, out_ready, lower_bound,       | out
//           | upper_bound, match_length, extended      |
//
// Load items give no result. In a query item, every probe is a suffix
// store read followed by a dependent text store read and a compare.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
// A stalled output holds the sequencer in its report step; loads are still
// taken while a result waits.
// ----------------------------------------------------------------------------
module suffix_array_interval_search_core import sais_pkg::*; #(
  parameter int MAX_TEXT  = MAX_TEXT_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [IDX_W-1:0]   load_address,
  input  logic [IDX_W-1:0]   load_value,
  input  logic [QCHAR_W-1:0] query_char,
  input  logic               new_query,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   lower_bound,
  output logic [IDX_W-1:0]   upper_bound,
  output logic [LEN_W-1:0]   match_length,
  output logic               extended
);

  sais_cmd_t  cmd;
  sais_stat_t stat;

  assign cfg_ready = 1'b1;

  sais_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sais_dp #(.MAX_TEXT(MAX_TEXT), .CHAR_BITS(CHAR_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .load_address (load_address),
    .load_value   (load_value),
    .query_char   (query_char),
    .new_query    (new_query),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .match_length (match_length),
    .extended     (extended),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ===== design/sais_checker.sv =====
// ----------------------------------------------------------------------------
// sais_checker
// Port-level checks of the search core, bound to the top level.
// ----------------------------------------------------------------------------
module sais_checker import sais_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IDX_W-1:0]   lower_bound,
  input logic [IDX_W-1:0]   upper_bound,
  input logic [LEN_W-1:0]   match_length,
  input logic               extended
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lower_bound) &&
      $stable(upper_bound) && $stable(match_length) && $stable(extended))
    else $error("result changed while stalled");

  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lower_bound <= upper_bound)
    else $error("interval bounds out of order");

  a_ext_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && extended |-> match_length != '0)
    else $error("extended item with zero match length");

  // a taken query item leaves the core busy, so in_ready drops
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
    else $error("input taken right after a query item");

endmodule

bind suffix_array_interval_search_core sais_checker u_sais_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the suffix array interval search core. Loads
// texts and their suffix arrays, walks query patterns through the block and
// compares every interval report with a behavioral copy of the search.
// ----------------------------------------------------------------------------
module tb_top;
  import sais_pkg::*;

  localparam logic [1:0] OP_NONE       = 2'd3;   // undefined opcode, dropped
  localparam int         SETTLE_CYCLES = 100;
  localparam int         LONG_HOLD     = 400;
  localparam int         RANDOM_ITEMS  = 2000;
  localparam int         RUN_LIMIT_NS  = 50_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [LEN_W-1:0] mlen;
    logic             ext;
  } interval_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = OP_TEXT;
  logic [IDX_W-1:0]   load_address = '0;
  logic [IDX_W-1:0]   load_value = '0;
  logic [QCHAR_W-1:0] query_char = '0;
  logic               new_query = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   lower_bound;
  logic [IDX_W-1:0]   upper_bound;
  logic [LEN_W-1:0]   match_length;
  logic               extended;

  // Behavioral copy of the block state
  logic [QCHAR_W-1:0] text_copy   [0:ADDR_SPACE-1];
  logic [IDX_W-1:0]   suffix_copy [0:ADDR_SPACE-1];
  logic [IDX_W-1:0]   cur_low     = '0;
  logic [IDX_W-1:0]   cur_high    = '0;
  logic [LEN_W-1:0]   cur_matched = '0;
  bit                 cur_stopped = 1'b0;
  logic [LEN_W-1:0]   cur_length  = 13'd1;

  interval_report_t pending_reports[$];
  int  order_a [0:ADDR_SPACE-1];
  int  order_b [0:ADDR_SPACE-1];
  int  fail_count     = 0;
  int  accepted_items = 0;
  bit  idle_on        = 1'b1;
  bit  hold_request   = 1'b0;

  always #10 clk = ~clk;

  suffix_array_interval_search_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .load_address (load_address),
    .load_value   (load_value),
    .query_char   (query_char),
    .new_query    (new_query),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .match_length (match_length),
    .extended     (extended)
  );

  // ---------------------------------------------------------------------------
  // Search prediction
  // ---------------------------------------------------------------------------
  function automatic int eff_len();
    int n;
    n = int'(cur_length);
    if (n < 1) n = 1;
    if (n > ADDR_SPACE) n = ADDR_SPACE;
    return n;
  endfunction

  // byte at suffix start plus matched length, zero past the text
  function automatic int probe_byte(int idx);
    int pos;
    pos = int'(suffix_copy[idx]) + int'(cur_matched);
    return (pos >= eff_len()) ? 0 : int'(text_copy[pos]);
  endfunction

  function automatic bit narrow_interval(input int ch, output logic [IDX_W-1:0] nlo,
                                         output logic [IDX_W-1:0] nhi);
    int n, lo, hi, l, r, m;
    n   = eff_len();
    lo  = int'(cur_low);
    hi  = int'(cur_high);
    nlo = '0;
    nhi = '0;
    if (lo > n - 1 || hi > n - 1 || lo > hi) return 1'b0;
    l = lo;
    r = hi;
    while (l < r) begin
      m = (l + r) / 2;
      if (probe_byte(m) >= ch) r = m;
      else l = m + 1;
    end
    if (probe_byte(l) != ch) return 1'b0;
    nlo = IDX_W'(l);
    l = lo;
    r = hi;
    while (l < r) begin
      m = (l + r + 1) / 2;
      if (probe_byte(m) > ch) r = m - 1;
      else l = m;
    end
    if (probe_byte(r) != ch) return 1'b0;
    nhi = IDX_W'(r);
    return 1'b1;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [IDX_W-1:0] addr,
                                       logic [IDX_W-1:0] val, logic [QCHAR_W-1:0] ch,
                                       logic nq);
    interval_report_t rep;
    logic [IDX_W-1:0] nlo, nhi;
    case (op)
      OP_TEXT:   text_copy[addr] = val[QCHAR_W-1:0];
      OP_SUFFIX: suffix_copy[addr] = val;
      OP_QUERY: begin
        if (nq) begin
          cur_low     = '0;
          cur_high    = IDX_W'(eff_len() - 1);
          cur_matched = '0;
          cur_stopped = 1'b0;
        end
        rep.ext = 1'b0;
        if (!cur_stopped) begin
          if (narrow_interval(int'(ch), nlo, nhi)) begin
            cur_low  = nlo;
            cur_high = nhi;
            if (cur_matched != COUNT_MAX) cur_matched = cur_matched + LEN_W'(1);
            rep.ext = 1'b1;
          end else begin
            cur_stopped = 1'b1;
          end
        end
        rep.lo   = cur_low;
        rep.hi   = cur_high;
        rep.mlen = cur_matched;
        pending_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  // lexical order with the end of the text below every byte
  function automatic bit suffix_not_after(int a, int b, int n);
    int k, ca, cb;
    for (k = 0; a + k < n || b + k < n; k++) begin
      ca = (a + k < n) ? int'(text_copy[a + k]) : -1;
      cb = (b + k < n) ? int'(text_copy[b + k]) : -1;
      if (ca != cb) return ca < cb;
    end
    return 1'b1;
  endfunction

  // bottom-up merge sort of the suffixes of the first n text bytes
  function automatic void build_suffix_order(int n);
    int w, lo, mid, hi, i, j, k;
    for (i = 0; i < n; i++) order_a[i] = i;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w < n) ? lo + w : n;
        hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
        i = lo;
        j = mid;
        for (k = lo; k < hi; k++) begin
          if (i < mid && (j >= hi || suffix_not_after(order_a[i], order_a[j], n))) begin
            order_b[k] = order_a[i];
            i++;
          end else begin
            order_b[k] = order_a[j];
            j++;
          end
        end
      end
      for (i = 0; i < n; i++) order_a[i] = order_b[i];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item and register traffic
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] addr,
                           input logic [IDX_W-1:0] val, input logic [QCHAR_W-1:0] ch,
                           input logic nq);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    load_address <= addr;
    load_value   <= val;
    query_char   <= ch;
    new_query    <= nq;
    do @(posedge clk); while (!in_ready);
    predict_item(op, addr, val, ch, nq);
    if (op != OP_NONE) accepted_items++;
  endtask

  task automatic load_text(input int addr, input int val);
    send_item(OP_TEXT, IDX_W'(addr), IDX_W'(val), QCHAR_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic load_suffix(input int addr, input int val);
    send_item(OP_SUFFIX, IDX_W'(addr), IDX_W'(val), QCHAR_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_query(input int ch, input bit nq);
    send_item(OP_QUERY, IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)),
              QCHAR_W'(ch), nq);
  endtask

  // drop valid and hold until every report is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_text_length(input logic [LEN_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_length = value;
  endtask

  // random text over a small alphabet (or all bytes), then its suffix array
  task automatic load_random_text(input int n, input int alpha);
    int i, base;
    base = (alpha >= 256) ? 0 : $urandom_range(0, 256 - alpha);
    for (i = 0; i < n; i++)
      load_text(i, int'({4'($urandom_range(0, 15)),
                         8'(base + $urandom_range(0, alpha - 1))}));
    build_suffix_order(n);
    for (i = 0; i < n; i++) load_suffix(i, order_a[i]);
  endtask

  // walk a substring of the text, optionally with one wrong character
  task automatic query_pattern(input int start, input int plen, input bit broken);
    int k, pos, cut, ch;
    cut = broken ? $urandom_range(0, plen - 1) : plen;
    for (k = 0; k < plen; k++) begin
      pos = start + k;
      ch  = (pos < eff_len()) ? int'(text_copy[pos]) : 0;
      if (k == cut) ch = $urandom_range(0, 255);
      send_query(ch, k == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    load_text(0, 'hF41);
    load_suffix(0, 0);
    load_text(1, 'hFFF);
    send_query('h41, 1'b0);   // continue from the reset interval
    send_query('h00, 1'b0);   // past the text end: zero byte
    send_query('h80, 1'b0);   // not found, stop the query
    send_query('h41, 1'b0);   // stopped: held interval
    send_query('hFF, 1'b1);
    send_query('h41, 1'b1);
    send_item(OP_NONE, 12'hFFF, 12'hFFF, 8'hFF, 1'b1);
  endtask

  task automatic test_full_fill();
    load_random_text(ADDR_SPACE, 4);
  endtask

  task automatic test_length_extremes();
    set_text_length(13'd4096);
    query_pattern($urandom_range(0, ADDR_SPACE - 1), 6, 1'b0);
    query_pattern(ADDR_SPACE - 3, 5, 1'b0);
    send_query('hFF, 1'b1);
    send_query('h00, 1'b1);
    set_text_length(COUNT_MAX);
    query_pattern($urandom_range(0, ADDR_SPACE - 1), 4, 1'b1);
    set_text_length('0);
    send_query('h00, 1'b1);
    send_query(int'(text_copy[0]), 1'b1);
    set_text_length(13'd1);
    send_query($urandom_range(0, 255), 1'b1);
  endtask

  // interval that ends at the last entry, then shrink the text under it
  task automatic test_shrunk_interval();
    int top_char;
    set_text_length(13'd4096);
    top_char = int'(text_copy[suffix_copy[ADDR_SPACE - 1]]);
    send_query(top_char, 1'b1);
    set_text_length(13'd16);
    send_query(top_char, 1'b0);
    send_query(top_char, 1'b1);
  endtask

  task automatic test_stall_pressure();
    int k, start;
    wait_drained();
    hold_request = 1'b1;
    idle_on      = 1'b0;
    start        = $urandom_range(0, 15);
    for (k = 0; k < 10; k++) begin
      send_query((start + k < 16) ? int'(text_copy[start + k]) : 0, k == 0);
      load_text(ADDR_SPACE - 1 - k, $urandom_range(0, 4095));
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  // zero bytes match forever at length one: run the count into its ceiling
  task automatic test_count_saturation();
    set_text_length(13'd1);
    load_text(0, 'h100);
    load_suffix(0, 0);
    idle_on = 1'b0;
    send_query(0, 1'b1);
    repeat (int'(COUNT_MAX)) send_query(0, 1'b0);
    send_query(1, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_rounds();
    int n, alpha, pick, first_item;
    first_item = accepted_items;
    while (accepted_items - first_item < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 7) == 0) ? ADDR_SPACE : $urandom_range(2, 48);
      set_text_length(LEN_W'(n));
      if (n < ADDR_SPACE) begin
        alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
        load_random_text(n, alpha);
      end
      if ($urandom_range(0, 9) == 0) hold_request = 1'b1;
      repeat ($urandom_range(6, 16)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          query_pattern($urandom_range(0, n - 1), $urandom_range(1, 10), pick == 6);
        end else if (pick == 7) begin
          send_query($urandom_range(0, 255), 1'($urandom_range(0, 1)));
        end else if (pick == 8) begin
          send_item(OP_NONE, IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)),
                    QCHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (n < ADDR_SPACE) begin
          // stray load outside the text in use
          if ($urandom_range(0, 1)) load_text($urandom_range(n, ADDR_SPACE - 1),
                                              $urandom_range(0, 4095));
          else load_suffix($urandom_range(n, ADDR_SPACE - 1), $urandom_range(0, 4095));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [LEN_W-1:0] want,
                                        logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin : report_sink
    int stall;
    interval_report_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_reports.size() == 0) begin
        $error("unexpected result: lower_bound %0d upper_bound %0d match_length %0d",
               lower_bound, upper_bound, match_length);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("lower_bound", LEN_W'(want.lo), LEN_W'(lower_bound));
        compare_field("upper_bound", LEN_W'(want.hi), LEN_W'(upper_bound));
        compare_field("match_length", want.mlen, match_length);
        compare_field("extended", LEN_W'(want.ext), LEN_W'(extended));
      end
    end
  end

  initial begin : test_sequence
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_fill();
    test_length_extremes();
    test_shrunk_interval();
    test_stall_pressure();
    test_count_saturation();
    test_random_rounds();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("suffix_array_interval_search_core: match");
    end else begin
      $display("suffix_array_interval_search_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("suffix_array_interval_search_core: mismatch");
    $finish;
  end

endmodule

// ===== suffix_array_interval_search_core.f =====
design/sais_pkg.sv
design/sais_ram.sv
design/sais_ctrl.sv
design/sais_dp.sv
design/suffix_array_interval_search_core.sv
design/sais_checker.sv
test/tb_top.sv
